[sv/srh_pkg.sv]
`timescale 1ns / 1ps
package srh_pkg;
   typedef enum logic [2:0] {
      CMD_TICK = 3'd0, CMD_MOVE_ABS = 3'd1, CMD_MOVE_REL = 3'd2,
      CMD_SET_POS = 3'd3, CMD_HOME = 3'd4
   } cmd_type;
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_AWAY = 2'd1;
   localparam logic [1:0] PH_TOWARD = 2'd2;
   localparam logic [2:0] HS_NONE = 3'd0;
   localparam logic [2:0] HS_BUSY = 3'd1;
   localparam logic [2:0] HS_DONE = 3'd2;
   localparam logic [2:0] HS_STUCK_HIGH = 3'd3;
   localparam logic [2:0] HS_STUCK_LOW = 3'd4;
   localparam logic [2:0] CSR_MIN_PERIOD = 3'd0;
   localparam logic [2:0] CSR_INIT_PERIOD = 3'd1;
   localparam logic [2:0] CSR_DECEL_STEPS = 3'd2;
   localparam logic [2:0] CSR_ACCEL = 3'd3;
   localparam logic [2:0] CSR_HOME_DIR = 3'd4;
   localparam logic [2:0] CSR_HOME_DIST = 3'd5;
endpackage

[sv/stepper_ramp_and_homing.sv]
`timescale 1ns / 1ps
// Trapezoidal stepper ramp generator with homing. Each req word is a command
// (tick, move absolute/relative, set position, start homing); each produces
// exactly one rsp word with step, direction, position, done and homing status.
// Non-stepping words go straight to the output state. A tick that steps runs the
// period update p*(1-/+a*p*p) through one shared 48x64 bit-serial multiplier
// three times (p*p, a*p*p and p*t, in states MUL1, MUL2 and MUL3) before the
// output state makes the rsp word valid.
// Only one word is in work at a time: a new word is taken when no rsp word is
// pending, or in the same cycle the pending rsp word is accepted.
module stepper_ramp_and_homing (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_cmd,
   input  logic signed [31:0] req_value,
   input  logic               req_endstop_active,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_step_pulse,
   output logic               rsp_dir_negative,
   output logic signed [31:0] rsp_position,
   output logic               rsp_motion_done,
   output logic [2:0]         rsp_homing_status,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [47:0]        csr_wdata
);
   typedef enum logic [4:0] {
      S_IDLE = 5'b00001, S_MUL1 = 5'b00010, S_MUL2 = 5'b00100,
      S_MUL3 = 5'b01000, S_OUT = 5'b10000
   } state_type;

   // config
   logic [31:0] min_p_ff, init_p_ff;
   logic [30:0] dsteps_ff;
   logic [47:0] accel_ff;
   logic        hdir_ff;
   logic [29:0] hdist_ff;

   // block state
   logic [31:0] pos_ff, pos_in, tgt_ff, tgt_in, per_ff, per_in, tk_ff, tk_in;
   logic [30:0] ads_ff, ads_in;
   logic        neg_ff, neg_in, dec_ff, dec_in;
   logic [1:0]  ph_ff, ph_in;
   logic [2:0]  hr_ff, hr_in;
   logic        step_ff, step_in;
   state_type   st_ff, st_in;
   logic        rv_ff, rv_in;
   logic [63:0] t_ff, t_in;   // p*p, then a*p*p>>48 capped

   logic        mstart, mdone;
   logic [47:0] ma;
   logic [63:0] mb;
   logic [111:0] mprod;

   srh_serial_mul #(.AW(48), .BW(64)) u_mul (
      .clock(clock), .reset(reset), .start(mstart), .a(ma), .b(mb),
      .done(mdone), .prod(mprod));

   wire accept = req_valid && req_ready;
   assign req_ready = (st_ff == S_IDLE) && !(rv_ff && !rsp_ready);

   function automatic logic [31:0] absd(input logic [31:0] d);
      return d[31] ? (32'd0 - d) : d;
   endfunction

   logic [31:0] hd_ext, mv_tgt, dd, mag;
   logic        do_setup, do_motion, run_done;
   logic [32:0] t33;
   logic [63:0] np64;
   logic [39:0] pt;
   logic [31:0] np;

   always_comb begin
      pos_in = pos_ff; tgt_in = tgt_ff; per_in = per_ff; tk_in = tk_ff;
      ads_in = ads_ff; neg_in = neg_ff; dec_in = dec_ff; ph_in = ph_ff;
      hr_in = hr_ff; step_in = step_ff; st_in = st_ff; rv_in = rv_ff;
      t_in = t_ff; mstart = 1'b0; ma = '0; mb = '0;
      do_setup = 1'b0; mv_tgt = '0; do_motion = 1'b0; run_done = 1'b0;
      hd_ext = {2'b00, hdist_ff};
      dd = '0; mag = '0; t33 = '0; np64 = '0; pt = '0; np = '0;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      case (st_ff)
         S_IDLE: begin
            if (accept) begin
               step_in = 1'b0;
               st_in = S_OUT;
               case (req_cmd)
                  srh_pkg::CMD_TICK: begin
                     if (ph_ff == srh_pkg::PH_AWAY) begin
                        if (req_endstop_active) do_motion = 1'b1;
                        else begin
                           do_setup = 1'b1;
                           mv_tgt = pos_ff + (hdir_ff ? hd_ext : 32'd0 - hd_ext);
                           ph_in = srh_pkg::PH_TOWARD; hr_in = srh_pkg::HS_BUSY;
                        end
                     end else if (ph_ff == srh_pkg::PH_TOWARD) begin
                        if (req_endstop_active) begin
                           pos_in = '0; tgt_in = '0; ph_in = srh_pkg::PH_IDLE;
                           hr_in = srh_pkg::HS_DONE;
                        end else do_motion = 1'b1;
                     end else do_motion = 1'b1;
                  end
                  srh_pkg::CMD_MOVE_ABS, srh_pkg::CMD_MOVE_REL: begin
                     if (ph_ff != srh_pkg::PH_IDLE) begin
                        ph_in = srh_pkg::PH_IDLE; hr_in = srh_pkg::HS_NONE;
                     end
                     do_setup = 1'b1;
                     mv_tgt = (req_cmd == srh_pkg::CMD_MOVE_ABS) ? req_value
                              : pos_ff + req_value;
                  end
                  srh_pkg::CMD_SET_POS: begin
                     pos_in = req_value; tgt_in = req_value;
                  end
                  srh_pkg::CMD_HOME: begin
                     do_setup = 1'b1;
                     if (req_endstop_active) begin
                        mv_tgt = pos_ff + (!hdir_ff ? hd_ext : 32'd0 - hd_ext);
                        ph_in = srh_pkg::PH_AWAY;
                     end else begin
                        mv_tgt = pos_ff + (hdir_ff ? hd_ext : 32'd0 - hd_ext);
                        ph_in = srh_pkg::PH_TOWARD;
                     end
                     hr_in = srh_pkg::HS_BUSY;
                  end
                  default: ;
               endcase
               if (do_setup) begin
                  dd = mv_tgt - pos_ff;
                  mag = absd(dd);
                  tgt_in = mv_tgt; neg_in = dd[31];
                  ads_in = ({1'b0, mag} <= {1'b0, dsteps_ff, 1'b0})
                           ? mag[31:1] : dsteps_ff;
                  per_in = init_p_ff; dec_in = 1'b0; tk_in = '0;
               end
               if (do_motion) begin
                  if (pos_ff == tgt_ff) run_done = 1'b1;
                  else if (tk_ff < {12'd0, per_ff[31:12]}) begin
                     tk_in = (tk_ff == '1) ? tk_ff : tk_ff + 1'b1;
                  end else begin
                     if (absd(tgt_ff - pos_ff) == {1'b0, ads_ff}) dec_in = !dec_ff;
                     pos_in = pos_ff + (neg_ff ? 32'hFFFF_FFFF : 32'd1);
                     run_done = (pos_ff + (neg_ff ? 32'hFFFF_FFFF : 32'd1)) == tgt_ff;
                     step_in = 1'b1; tk_in = 32'd1;
                     st_in = S_MUL1;
                     mstart = 1'b1; ma = {16'd0, per_ff}; mb = {32'd0, per_ff};
                  end
                  if (ph_ff == srh_pkg::PH_AWAY) begin
                     if (run_done) begin
                        ph_in = srh_pkg::PH_IDLE; hr_in = srh_pkg::HS_STUCK_HIGH;
                     end else hr_in = srh_pkg::HS_BUSY;
                  end else if (ph_ff == srh_pkg::PH_TOWARD) begin
                     if (run_done) begin
                        ph_in = srh_pkg::PH_IDLE; hr_in = srh_pkg::HS_STUCK_LOW;
                     end else hr_in = srh_pkg::HS_BUSY;
                  end
               end
            end
         end
         S_MUL1: begin
            if (mdone) begin
               t_in = mprod[63:0];
               mstart = 1'b1; ma = accel_ff; mb = mprod[63:0];
               st_in = S_MUL2;
            end
         end
         S_MUL2: begin
            if (mdone) begin
               // factor capped at 1.0 in Q.32 terms
               t33 = (mprod[111:48] > 64'h1_0000_0000) ? 33'h1_0000_0000 : mprod[80:48];
               t_in = {31'd0, t33};
               mstart = 1'b1; ma = {16'd0, per_ff}; mb = {31'd0, t33};
               st_in = S_MUL3;
            end
         end
         S_MUL3: begin
            if (mdone) begin
               pt = mprod[63:24];
               if (!dec_ff) begin
                  np64 = (t_ff[32:24] != '0) ? 64'd0 : {32'd0, per_ff} - {24'd0, pt};
               end else begin
                  np64 = {32'd0, per_ff} + {24'd0, pt};
                  if (np64[63:32] != '0) np64 = 64'h0000_0000_FFFF_FFFF;
               end
               np = np64[31:0];
               per_in = (np < min_p_ff) ? min_p_ff : np;
               st_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rv_ff || rsp_ready) begin
               rv_in = 1'b1; st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      t_ff <= t_in;
      if (reset) begin
         min_p_ff <= 32'd20480000; init_p_ff <= 32'd204800000; dsteps_ff <= 31'd100;
         accel_ff <= 48'd56295; hdir_ff <= 1'b0; hdist_ff <= 30'd10000;
         pos_ff <= '0; tgt_ff <= '0; per_ff <= '0; tk_ff <= '0; ads_ff <= '0;
         neg_ff <= 1'b0; dec_ff <= 1'b0; ph_ff <= srh_pkg::PH_IDLE;
         hr_ff <= srh_pkg::HS_NONE; step_ff <= 1'b0; st_ff <= S_IDLE; rv_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in; tgt_ff <= tgt_in; per_ff <= per_in; tk_ff <= tk_in;
         ads_ff <= ads_in; neg_ff <= neg_in; dec_ff <= dec_in; ph_ff <= ph_in;
         hr_ff <= hr_in; step_ff <= step_in; st_ff <= st_in; rv_ff <= rv_in;
         if (csr_we) begin
            case (csr_index)
               srh_pkg::CSR_MIN_PERIOD:  min_p_ff <= csr_wdata[31:0];
               srh_pkg::CSR_INIT_PERIOD: init_p_ff <= csr_wdata[31:0];
               srh_pkg::CSR_DECEL_STEPS: dsteps_ff <= csr_wdata[30:0];
               srh_pkg::CSR_ACCEL:       accel_ff <= csr_wdata;
               srh_pkg::CSR_HOME_DIR:    hdir_ff <= csr_wdata[0];
               srh_pkg::CSR_HOME_DIST:   hdist_ff <= csr_wdata[29:0];
               default: ;
            endcase
         end
      end
   end

   // rsp word holds the architectural state, stable while no word is in work
   assign rsp_valid = rv_ff;
   assign rsp_step_pulse = step_ff;
   assign rsp_dir_negative = neg_ff;
   assign rsp_position = pos_ff;
   assign rsp_motion_done = (pos_ff == tgt_ff);
   assign rsp_homing_status = hr_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != S_IDLE) |-> !req_ready) else $error("accept while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && !rsp_ready) |=> (rv_ff && $stable(pos_ff))) else $error("rsp lost");
   a_step_one: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_MUL1) |-> step_ff) else $error("ramp without step");
endmodule

[sv/srh_serial_mul.sv]
`timescale 1ns / 1ps
// Shift-add multiplier: one bit of b per cycle, product accumulated from the top.
module srh_serial_mul #(
   parameter int AW = 48,
   parameter int BW = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [AW-1:0]     a,
   input  logic [BW-1:0]     b,
   output logic              done,
   output logic [AW+BW-1:0]  prod
);
   localparam int CW = $clog2(BW + 1);
   logic [AW+BW-1:0] acc_ff, acc_in;
   logic [BW-1:0]    b_ff, b_in;
   logic [AW-1:0]    a_ff, a_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      acc_in = acc_ff; b_in = b_ff; a_in = a_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         acc_in = '0; a_in = a; b_in = b; cnt_in = CW'(BW); busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = {acc_ff[AW+BW-2:0], 1'b0} +
                  (b_ff[BW-1] ? {{BW{1'b0}}, a_ff} : '0);
         b_in = {b_ff[BW-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in; a_ff <= a_in; b_ff <= b_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;
endmodule
